// ===== rtl/core/murmur2_64bit_key_hash_unit_macros.svh =====
// Assertion macros shared by the hash core files.
`ifndef MURMUR2_64BIT_KEY_HASH_UNIT_MACROS_SVH
`define MURMUR2_64BIT_KEY_HASH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define M2H_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define M2H_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define M2H_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define M2H_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/m2h_pkg.sv =====
`timescale 1ns / 1ps

package m2h_pkg;

    // Hash multiplier and shift distance
    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    // Request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_mul_req;

    // Response from the shared multiplier
    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_mul_rsp;

endpackage

// ===== rtl/core/m2h_const_mul.sv =====
`timescale 1ns / 1ps
`include "murmur2_64bit_key_hash_unit_macros.svh"

// Low 64 bits of operand * MIX_MUL, one 32x32 partial product per cycle.
module m2h_const_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  m2h_pkg::t_mul_req i_req,
    output m2h_pkg::t_mul_rsp o_rsp
);
    import m2h_pkg::*;

    localparam logic [1:0] STEP_LO      = 2'd0;
    localparam logic [1:0] STEP_CROSS_A = 2'd1;
    localparam logic [1:0] STEP_CROSS_B = 2'd2;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_acc;

    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_prod;

    // Partial product select
    always_comb begin
        case (r_step)
            STEP_LO: begin
                w_x = r_a[31:0];
                w_y = MIX_MUL[31:0];
            end
            STEP_CROSS_A: begin
                w_x = r_a[31:0];
                w_y = MIX_MUL[63:32];
            end
            default: begin
                w_x = r_a[63:32];
                w_y = MIX_MUL[31:0];
            end
        endcase
    end

    assign w_prod = {32'h0, w_x} * {32'h0, w_y};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LO;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LO;
            end else if (r_busy) begin
                if (r_step == STEP_CROSS_B) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    // Datapath: cross terms only reach the upper half
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.operand;
        end else if (r_busy) begin
            if (r_step == STEP_LO) begin
                r_acc <= w_prod;
            end else begin
                r_acc <= r_acc + {w_prod[31:0], 32'h0};
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

    `M2H_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, r_busy, !i_req.start)
    `M2H_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `M2H_ASSERT_NXT(a_last_step_done, i_clk, i_rst_n,
        r_busy && (r_step == STEP_CROSS_B) && !i_req.start, r_done)

endmodule

// ===== rtl/core/murmur2_64bit_key_hash_unit.sv =====
`timescale 1ns / 1ps
`include "murmur2_64bit_key_hash_unit_macros.svh"

// MurmurHash64A over a key streamed as little-endian 64-bit words.
// Input stream: one word per transaction. tuser flags the first word of a key
// (its key_length seeds the hash), tlast flags the final word. Words before
// the last should be full; a word with 1..7 bytes is folded in as a tail.
// Output stream: one 64-bit hash per key, after the last word.
// Configuration: i_cfg_wr_en writes the 64-bit seed; write it while idle.
// Every 64-bit multiply by the hash constant runs on one 32x32 multiplier,
// in three partial products.
// Per word: a full block takes 3 multiplies, a tail word 1, an empty word none;
// a first word adds one (key length), a last word adds the finalizer multiply
// and the output load. tready is high only between words.
// The hash waits in an output register; the next key's words are accepted
// while it waits, and only the next finalized hash stalls on it.
// Reset clears the seed, the running hash and the output valid flag.
module murmur2_64bit_key_hash_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration
    input  logic          i_cfg_wr_en,
    input  logic [63:0]   i_cfg_wr_data,
    // Input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [103:0]  i_s_axis_tdata,  // data_word[63:0], byte_count[67:64],
                                           // key_length[98:68], zero pad
    input  logic          i_s_axis_tuser,  // first_word
    input  logic          i_s_axis_tlast,  // last_word
    // Output stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata   // hash_value[63:0]
);
    import m2h_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PICK,
        ST_MIX1,
        ST_MIX2,
        ST_FOLD,
        ST_FIN,
        ST_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_seed;
    logic [63:0] r_hash, n_hash;
    logic [63:0] r_k, n_k;
    logic [63:0] r_word;
    logic [3:0]  r_count;
    logic        r_last;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_data, n_out_data;

    t_mul_req    w_req;
    t_mul_rsp    w_rsp;
    logic [63:0] w_tail_mask;
    logic        w_accept;

    m2h_const_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Tail byte mask
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_tail_mask[8*i +: 8] = (r_count > 4'(i)) ? 8'hff : 8'h00;
        end
    end

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'h0;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state       = r_state;
        n_hash        = r_hash;
        n_k           = r_k;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_data    = r_out_data;
        w_req.start   = 1'b0;
        w_req.operand = r_word;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser) begin
                        w_req.start   = 1'b1;
                        w_req.operand = {33'h0, i_s_axis_tdata[98:68]};
                        n_state       = ST_INIT;
                    end else begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_INIT: begin
                if (w_rsp.done) begin
                    n_hash  = r_seed ^ w_rsp.result;
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (r_count[3]) begin
                    w_req.start   = 1'b1;
                    w_req.operand = r_word;
                    n_state       = ST_MIX1;
                end else if (r_count != 4'd0) begin
                    w_req.start   = 1'b1;
                    w_req.operand = r_hash ^ (r_word & w_tail_mask);
                    n_state       = ST_FOLD;
                end else if (r_last) begin
                    w_req.start   = 1'b1;
                    w_req.operand = r_hash ^ (r_hash >> MIX_SHIFT);
                    n_state       = ST_FIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MIX1: begin
                if (w_rsp.done) begin
                    w_req.start   = 1'b1;
                    w_req.operand = w_rsp.result ^ (w_rsp.result >> MIX_SHIFT);
                    n_state       = ST_MIX2;
                end
            end
            ST_MIX2: begin
                if (w_rsp.done) begin
                    w_req.start   = 1'b1;
                    w_req.operand = r_hash ^ w_rsp.result;
                    n_state       = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (w_rsp.done) begin
                    n_hash = w_rsp.result;
                    if (r_last) begin
                        w_req.start   = 1'b1;
                        w_req.operand = w_rsp.result ^ (w_rsp.result >> MIX_SHIFT);
                        n_state       = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                // finalizer result stays out of the running hash
                if (w_rsp.done) begin
                    n_k     = w_rsp.result;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_k ^ (r_k >> MIX_SHIFT);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= 64'h0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_word  <= i_s_axis_tdata[63:0];
            r_count <= i_s_axis_tdata[67:64];
            r_last  <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `M2H_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != ST_IDLE)
    `M2H_ASSERT_IMP(a_done_in_mul_state, i_clk, i_rst_n, w_rsp.done,
        (r_state == ST_INIT) || (r_state == ST_MIX1) || (r_state == ST_MIX2) ||
        (r_state == ST_FOLD) || (r_state == ST_FIN))
    `M2H_ASSERT_NXT(a_out_load, i_clk, i_rst_n,
        (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready), r_out_valid)

endmodule
